// File: src/pidl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants of the leaky-integral pid core: register
// indexes, controller states and the command bundle to the datapath.
// ----------------------------------------------------------------------------
package pidl_pkg;

	localparam int unsigned DATA_W   = 16;
	localparam int unsigned ERR_W    = 17;
	localparam int unsigned DIFF_W   = 18;
	localparam int unsigned OUT_W    = 32;
	localparam int unsigned CFG_IDX_W = 3;

	// reset values of the leak factors, 0.5 in q1.15
	localparam logic [DATA_W-1:0] KEEP_RESET = 16'd16384;
	localparam logic [DATA_W-1:0] TAKE_RESET = 16'd16384;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P_GAIN     = 3'd0,
		REG_I_GAIN     = 3'd1,
		REG_D_GAIN     = 3'd2,
		REG_ACCUM_KEEP = 3'd3,
		REG_ACCUM_TAKE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [DATA_W-1:0] p_gain;
		logic [DATA_W-1:0] i_gain;
		logic [DATA_W-1:0] d_gain;
		logic [DATA_W-1:0] accum_keep;
		logic [DATA_W-1:0] accum_take;
	} cfg_t;

	// controller states, one per step of the product schedule
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAKE,
		ST_KEEP,
		ST_ACC,
		ST_PTERM,
		ST_ITERM,
		ST_DTERM,
		ST_CORR
	} state_t;

	// operand pairs of the shared multiplier
	typedef enum logic [2:0] {
		MUL_TAKE,
		MUL_KEEP,
		MUL_P,
		MUL_I,
		MUL_D
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    mul_en;
		mul_op_t mul_op;
		logic    sum_ld;
		logic    acc_ld;
		logic    tp_ld;
		logic    ti_ld;
		logic    drive_ld;
		logic    out_ld;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

// File: src/pidl_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidl_cfg
// Configuration register file: gains and leak factors, written by index.
// ----------------------------------------------------------------------------
module pidl_cfg
	import pidl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [DATA_W-1:0]    wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain     <= '0;
			cfg_q.i_gain     <= '0;
			cfg_q.d_gain     <= '0;
			cfg_q.accum_keep <= KEEP_RESET;
			cfg_q.accum_take <= TAKE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_P_GAIN:     cfg_q.p_gain     <= wr_data;
				REG_I_GAIN:     cfg_q.i_gain     <= wr_data;
				REG_D_GAIN:     cfg_q.d_gain     <= wr_data;
				REG_ACCUM_KEEP: cfg_q.accum_keep <= wr_data;
				REG_ACCUM_TAKE: cfg_q.accum_take <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: src/pidl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidl_ctrl
// Sequencer of the pid core: steps one request through the shared
// multiplier schedule and hands the result to the output register.
// ----------------------------------------------------------------------------
module pidl_ctrl
	import pidl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic sample_valid,
	input  status_t   status,
	output logic      busy,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.mul_op = MUL_TAKE;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d = ST_TAKE;
				end
			end
			ST_TAKE: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_TAKE;
				state_d = ST_KEEP;
			end
			ST_KEEP: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_KEEP;
				cmd.sum_ld = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_ld = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_P;
				state_d = ST_PTERM;
			end
			ST_PTERM: begin
				cmd.tp_ld = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_I;
				state_d = ST_ITERM;
			end
			ST_ITERM: begin
				cmd.ti_ld = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_D;
				state_d = ST_DTERM;
			end
			ST_DTERM: begin
				cmd.drive_ld = 1'b1;
				state_d = ST_CORR;
			end
			ST_CORR: begin
				// wait for room in the output register
				if (!status.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// File: src/pidl_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidl_dpath
// Datapath of the pid core: error and difference, one shared signed
// multiplier, the leaky accumulator, term saturation and the result register.
// ----------------------------------------------------------------------------
module pidl_dpath
	import pidl_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  cmd_t                          cmd,
	input  cfg_t                          cfg,
	input  wire logic signed [DATA_W-1:0] set_point,
	input  wire logic signed [DATA_W-1:0] measurement,
	input  wire logic                     result_stall,
	output status_t                       status,
	output logic                          result_valid,
	output logic signed [OUT_W-1:0]       drive,
	output logic signed [OUT_W-1:0]       corrected_value,
	output logic                          saturated
);

	localparam int unsigned MA_W  = 33;
	localparam int unsigned MB_W  = 18;
	localparam int unsigned MP_W  = MA_W + MB_W;
	localparam int unsigned SUM_W = 50;

	// clip to 32 bits, top bit of the result flags a clip
	function automatic logic [OUT_W:0] sat32(input logic signed [MP_W-1:0] x);
		logic [OUT_W:0] r;
		if (x > 51'sd2147483647) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (x < -51'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, x[OUT_W-1:0]};
		end
		return r;
	endfunction

	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  last_err_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [DATA_W-1:0] meas_q;
	logic signed [OUT_W-1:0]  accum_q;
	logic signed [MP_W-1:0]   mq_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [OUT_W-1:0]  tp_q;
	logic signed [OUT_W-1:0]  ti_q;
	logic signed [OUT_W-1:0]  drive_q;
	logic                     clip_q;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  drive_out_q;
	logic signed [OUT_W-1:0]  corr_out_q;
	logic                     sat_out_q;

	logic signed [ERR_W-1:0]  err_c;
	logic signed [DIFF_W-1:0] diff_c;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [MP_W-1:0]   prod_c;
	logic signed [SUM_W-1:0]  acc_sum_c;
	logic signed [MP_W-1:0]   acc_rnd_c;
	logic signed [MP_W-1:0]   ti_rnd_c;
	logic [OUT_W:0]           acc_sat_c;
	logic [OUT_W:0]           tp_sat_c;
	logic [OUT_W:0]           ti_sat_c;
	logic [OUT_W:0]           td_sat_c;
	logic [OUT_W:0]           drive_sat_c;
	logic [OUT_W:0]           corr_sat_c;
	logic signed [OUT_W+1:0]  term_sum_c;
	logic signed [OUT_W:0]    corr_sum_c;
	logic signed [OUT_W-1:0]  td_c;

	// error and difference of the incoming request
	assign err_c  = {set_point[DATA_W-1], set_point} - {measurement[DATA_W-1], measurement};
	assign diff_c = {err_c[ERR_W-1], err_c} - {last_err_q[ERR_W-1], last_err_q};

	// operand select of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_op)
			MUL_TAKE: begin
				mul_a = MA_W'(err_q);
				mul_b = {2'b00, cfg.accum_take};
			end
			MUL_KEEP: begin
				mul_a = MA_W'(accum_q);
				mul_b = {2'b00, cfg.accum_keep};
			end
			MUL_P: begin
				mul_a = MA_W'(err_q);
				mul_b = MB_W'(signed'(cfg.p_gain));
			end
			MUL_I: begin
				mul_a = MA_W'(accum_q);
				mul_b = MB_W'(signed'(cfg.i_gain));
			end
			MUL_D: begin
				mul_a = MA_W'(diff_q);
				mul_b = MB_W'(signed'(cfg.d_gain));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;

	// accumulator: sum at 23 fraction bits, round half up to 8
	assign acc_sum_c = sum_q + mq_q[SUM_W-1:0];
	assign acc_rnd_c = (MP_W'(acc_sum_c) + MP_W'(51'sd16384)) >>> 15;
	assign acc_sat_c = sat32(acc_rnd_c);

	// terms
	assign tp_sat_c = sat32(mq_q);
	assign ti_rnd_c = (mq_q + 51'sd128) >>> 8;
	assign ti_sat_c = sat32(ti_rnd_c);
	assign td_sat_c = sat32(mq_q);
	assign td_c     = signed'(td_sat_c[OUT_W-1:0]);

	// drive and corrected value
	assign term_sum_c  = (OUT_W+2)'(tp_q) + (OUT_W+2)'(ti_q) + (OUT_W+2)'(td_c);
	assign drive_sat_c = sat32(MP_W'(term_sum_c));
	assign corr_sum_c  = (OUT_W+1)'(signed'({meas_q, 8'h00})) + (OUT_W+1)'(drive_q);
	assign corr_sat_c  = sat32(MP_W'(corr_sum_c));

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			accum_q    <= '0;
		end else begin
			if (cmd.load) begin
				last_err_q <= err_c;
			end
			if (cmd.acc_ld) begin
				accum_q <= signed'(acc_sat_c[OUT_W-1:0]);
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q  <= err_c;
			diff_q <= diff_c;
			meas_q <= measurement;
		end
		if (cmd.mul_en) begin
			mq_q <= prod_c;
		end
		if (cmd.sum_ld) begin
			sum_q <= {mq_q[SUM_W-9:0], 8'h00};
		end
		if (cmd.tp_ld) begin
			tp_q <= signed'(tp_sat_c[OUT_W-1:0]);
		end
		if (cmd.ti_ld) begin
			ti_q <= signed'(ti_sat_c[OUT_W-1:0]);
		end
		if (cmd.drive_ld) begin
			drive_q <= signed'(drive_sat_c[OUT_W-1:0]);
		end
	end

	// clip flag over the whole step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			clip_q <= 1'b0;
		end else begin
			clip_q <= clip_q
				| (cmd.acc_ld & acc_sat_c[OUT_W])
				| (cmd.tp_ld & tp_sat_c[OUT_W])
				| (cmd.ti_ld & ti_sat_c[OUT_W])
				| (cmd.drive_ld & (td_sat_c[OUT_W] | drive_sat_c[OUT_W]));
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			drive_out_q <= drive_q;
			corr_out_q  <= signed'(corr_sat_c[OUT_W-1:0]);
			sat_out_q   <= clip_q | corr_sat_c[OUT_W];
		end
	end

	assign status.out_busy = out_valid_q & result_stall;
	assign result_valid    = out_valid_q;
	assign drive           = drive_out_q;
	assign corrected_value = corr_out_q;
	assign saturated       = sat_out_q;

endmodule
`default_nettype wire

// File: src/pid_leaky_integral_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_leaky_integral_core
// Fixed point pid controller with a leaky integral term.
// ----------------------------------------------------------------------------
// One request at a time: a sample is taken in the idle state and its result
// goes to the output register in the last step of the schedule; no new sample
// is accepted before then. The schedule is set by the single 33 x 18 signed
// multiplier, which forms the five products (error*take, accum*keep, P, I, D)
// one after another, plus the steps for accumulator rounding and the final
// sums. A result that is not taken holds the core in its last step; the next
// sample is accepted as soon as the result has moved to the output register.
// ----------------------------------------------------------------------------
module pid_leaky_integral_core
	import pidl_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// sample channel
	input  wire logic                     sample_valid,
	output logic                          sample_stall,
	input  wire logic signed [DATA_W-1:0] set_point,
	input  wire logic signed [DATA_W-1:0] measurement,
	// result channel
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output logic signed [OUT_W-1:0]       drive,
	output logic signed [OUT_W-1:0]       corrected_value,
	output logic                          saturated,
	// configuration channel
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [DATA_W-1:0]        cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;
	logic    busy;

	// configuration registers
	assign cfg_ready = 1'b1;

	pidl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// sequencer
	pidl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.status       (status),
		.busy         (busy),
		.cmd          (cmd)
	);

	assign sample_stall = busy;

	// datapath
	pidl_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg),
		.set_point       (set_point),
		.measurement     (measurement),
		.result_stall    (result_stall),
		.status          (status),
		.result_valid    (result_valid),
		.drive           (drive),
		.corrected_value (corrected_value),
		.saturated       (saturated)
	);

	// an accepted sample keeps the core busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("core not busy after sample accept");

	// result register is never overwritten while it holds an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !(result_valid && result_stall))
		else $error("result register overwritten");

	// at most one register stage of the schedule is loaded in a cycle
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.acc_ld, cmd.tp_ld, cmd.ti_ld, cmd.drive_ld, cmd.out_ld}))
		else $error("overlapping schedule steps");

endmodule
`default_nettype wire

// File: test/pid_leaky_integral_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_leaky_integral_core_tb
// Self-checking bench for the leaky-integral pid core. Sample requests are
// queued by phase, driven with random gaps and checked against a fixed point
// model of the controller kept in step with every accepted request. Gains and
// leak factors change between phases while the core is idle, including the
// extremes, and the result side stalls in random bursts plus one long hold.
// ----------------------------------------------------------------------------
module pid_leaky_integral_core_tb;
	import pidl_pkg::*;

	localparam int     SETTLE_CYCLES = 20;
	localparam int     HOLD_AT       = 400;
	localparam int     HOLD_CYCLES   = 300;
	localparam longint SAT_HI        = 64'sd2147483647;
	localparam longint SAT_LO        = -64'sd2147483648;

	typedef struct {
		logic signed [DATA_W-1:0] set_point;
		logic signed [DATA_W-1:0] measurement;
	} sample_t;

	typedef struct {
		logic signed [OUT_W-1:0] drive;
		logic signed [OUT_W-1:0] corrected;
		logic                    saturated;
	} pid_out_t;

	// corner values of a sample field
	localparam logic [DATA_W-1:0] CORNERS [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};

	logic                     clk             = 1'b0;
	logic                     arst_n          = 1'b0;
	logic                     sample_valid    = 1'b0;
	logic                     sample_stall;
	logic signed [DATA_W-1:0] set_point       = '0;
	logic signed [DATA_W-1:0] measurement     = '0;
	logic                     result_valid;
	logic                     result_stall    = 1'b0;
	logic signed [OUT_W-1:0]  drive;
	logic signed [OUT_W-1:0]  corrected_value;
	logic                     saturated;
	logic                     cfg_valid       = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index       = '0;
	logic [DATA_W-1:0]        cfg_data        = '0;

	// model copy of the registers and the controller state
	logic signed [DATA_W-1:0] kp_q     = '0;
	logic signed [DATA_W-1:0] ki_q     = '0;
	logic signed [DATA_W-1:0] kd_q     = '0;
	logic [DATA_W-1:0]        keep_q   = KEEP_RESET;
	logic [DATA_W-1:0]        take_q   = TAKE_RESET;
	logic signed [ERR_W-1:0]  err_prev = '0;
	logic signed [OUT_W-1:0]  leak_acc = '0;

	sample_t  pending_samples [$];
	pid_out_t expected_outputs [$];

	int n_errors   = 0;
	int n_sent     = 0;
	int gap_left   = 0;
	int stall_left = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	bit bursts_on  = 1'b1;

	pid_leaky_integral_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.set_point       (set_point),
		.measurement     (measurement),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.drive           (drive),
		.corrected_value (corrected_value),
		.saturated       (saturated),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// rounding right shift, half up
	function automatic longint round_half_up(input longint x, input int n);
		return (x + (longint'(1) << (n - 1))) >>> n;
	endfunction

	// clip to 32 bits and flag it
	function automatic longint clip32(input longint x, inout bit clip);
		if (x > SAT_HI) begin
			clip = 1'b1;
			return SAT_HI;
		end
		if (x < SAT_LO) begin
			clip = 1'b1;
			return SAT_LO;
		end
		return x;
	endfunction

	// one controller step: updates the model state, returns the outputs
	function automatic pid_out_t pid_step(input logic signed [DATA_W-1:0] sp,
			input logic signed [DATA_W-1:0] meas);
		longint s, m, err, diff, acc, tp, ti, td, sum, corr;
		longint kp, ki, kd, keep, take, prev, accum;
		bit clip;
		pid_out_t r;
		clip  = 1'b0;
		s     = sp;
		m     = meas;
		kp    = kp_q;
		ki    = ki_q;
		kd    = kd_q;
		keep  = keep_q;
		take  = take_q;
		prev  = err_prev;
		accum = leak_acc;
		err   = s - m;
		diff  = err - prev;
		acc   = clip32(round_half_up(err * take * 256 + accum * keep, 15), clip);
		leak_acc = acc[OUT_W-1:0];
		err_prev = err[ERR_W-1:0];
		tp   = clip32(kp * err, clip);
		ti   = clip32(round_half_up(ki * acc, 8), clip);
		td   = clip32(kd * diff, clip);
		sum  = clip32(tp + ti + td, clip);
		corr = clip32(m * 256 + sum, clip);
		r.drive     = sum[OUT_W-1:0];
		r.corrected = corr[OUT_W-1:0];
		r.saturated = clip;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %0s: got %0d, expected %0d at %0t", what, got, want, $time);
		n_errors++;
	endtask

	// sample driver: one request per handshake, random gaps between them
	always @(posedge clk) begin : sample_driver
		sample_t nxt;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				expected_outputs.push_back(pid_step(set_point, measurement));
				n_sent <= n_sent + 1;
			end
			if (!sample_valid || !sample_stall) begin
				if (gap_left > 0) begin
					sample_valid <= 1'b0;
					gap_left     <= gap_left - 1;
				end else if (pending_samples.size() > 0) begin
					nxt = pending_samples.pop_front();
					sample_valid <= 1'b1;
					set_point    <= nxt.set_point;
					measurement  <= nxt.measurement;
					if (bursts_on && $urandom_range(0, 11) == 0)
						gap_left <= $urandom_range(1, 19);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// one long hold on the result side so the core backs up into its input
	always @(posedge clk) begin : long_hold
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && n_sent >= HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	// result monitor and stall bursts
	always @(posedge clk) begin : result_monitor
		int burst;
		pid_out_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch("result with no request pending, drive", drive, 0);
				end else begin
					want = expected_outputs.pop_front();
					if (drive !== want.drive)
						report_mismatch("drive", drive, want.drive);
					if (corrected_value !== want.corrected)
						report_mismatch("corrected_value", corrected_value, want.corrected);
					if (saturated !== want.saturated)
						report_mismatch("saturated", saturated, want.saturated);
				end
			end
			burst = stall_left;
			if (burst > 0)
				burst = burst - 1;
			else if (bursts_on && $urandom_range(0, 9) == 0)
				burst = $urandom_range(1, 19);
			stall_left   <= burst;
			result_stall <= (hold_left != 0) || (burst != 0);
		end
	end

	// register write over the configuration channel, mirrored into the model
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_P_GAIN:     kp_q   = val;
			REG_I_GAIN:     ki_q   = val;
			REG_D_GAIN:     kd_q   = val;
			REG_ACCUM_KEEP: keep_q = val;
			REG_ACCUM_TAKE: take_q = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
			input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] keep,
			input logic [DATA_W-1:0] take);
		write_reg(REG_P_GAIN, kp);
		write_reg(REG_I_GAIN, ki);
		write_reg(REG_D_GAIN, kd);
		write_reg(REG_ACCUM_KEEP, keep);
		write_reg(REG_ACCUM_TAKE, take);
	endtask

	// a write to an index past the register list, which must change nothing
	task automatic write_spare();
		logic [CFG_IDX_W-1:0] idx;
		idx = CFG_IDX_W'($urandom_range(REG_ACCUM_TAKE + 1, (1 << CFG_IDX_W) - 1));
		write_reg(idx, DATA_W'($urandom));
	endtask

	function automatic logic [DATA_W-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0, 1: return DATA_W'($urandom);
			2:    return DATA_W'($urandom_range(0, 2048) - 1024);
			3:    return DATA_W'($urandom_range(0, 256) - 128);
			default: return CORNERS[$urandom_range(0, 4)];
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_factor();
		case ($urandom_range(0, 6))
			0:    return DATA_W'($urandom);
			1, 2: return DATA_W'($urandom_range(20000, 32768));
			3:    return 16'h8000;
			4:    return 16'h0000;
			5:    return 16'hFFFF;
			default: return DATA_W'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic random_config();
		write_all(rand_gain(), rand_gain(), rand_gain(), rand_factor(), rand_factor());
		if ($urandom_range(0, 2) == 0)
			write_spare();
	endtask

	function automatic sample_t rand_sample();
		sample_t s;
		logic signed [DATA_W-1:0] base;
		case ($urandom_range(0, 5))
			0, 1: begin
				s.set_point   = DATA_W'($urandom);
				s.measurement = DATA_W'($urandom);
			end
			2: begin
				s.set_point   = DATA_W'($urandom_range(0, 600) - 300);
				s.measurement = DATA_W'($urandom_range(0, 600) - 300);
			end
			3: begin
				s.set_point   = CORNERS[$urandom_range(0, 4)];
				s.measurement = CORNERS[$urandom_range(0, 4)];
			end
			default: begin
				// small error around an arbitrary operating point
				base          = DATA_W'($urandom);
				s.measurement = base;
				s.set_point   = base + DATA_W'($urandom_range(0, 64) - 32);
			end
		endcase
		return s;
	endfunction

	task automatic queue_sample(input logic signed [DATA_W-1:0] sp,
			input logic signed [DATA_W-1:0] meas);
		sample_t s;
		s.set_point   = sp;
		s.measurement = meas;
		pending_samples.push_back(s);
	endtask

	// random requests, now and then a run of one value to build up the integral
	task automatic queue_random(input int count);
		sample_t s;
		int run;
		for (int i = 0; i < count; ) begin
			s   = rand_sample();
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 10) : 1;
			for (int j = 0; j < run && i < count; j++) begin
				pending_samples.push_back(s);
				i++;
			end
		end
	endtask

	// all requests sent and answered, then let the core settle
	task automatic wait_drained();
		while (pending_samples.size() != 0 || sample_valid || expected_outputs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero gains, only the measurement passes through
		queue_sample(16'sd100, 16'sd40);
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);
		wait_drained();

		// moderate gains, field extremes and unit steps
		write_all(16'h0100, 16'h0080, 16'h0040, KEEP_RESET, TAKE_RESET);
		queue_sample(16'sd0, 16'sd0);
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);
		queue_sample(16'sh7FFF, 16'sh7FFF);
		queue_sample(16'sh8000, 16'sh8000);
		queue_sample(16'sd1, 16'sd0);
		queue_sample(16'sd0, 16'sd1);
		queue_sample(-16'sd1, 16'sd0);
		wait_drained();

		// largest gains and leak factors near 2.0: the integral runs into saturation
		write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
		repeat (6) queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);
		wait_drained();

		// most negative gains, nothing kept, error taken at 1.0
		write_all(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h8000);
		write_spare();
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);
		queue_sample(16'sd0, 16'sd0);
		queue_sample(16'sh8000, 16'sh8000);
		wait_drained();

		// random phases, each under its own settings
		for (int ph = 0; ph < 6; ph++) begin
			random_config();
			queue_random(200);
			wait_drained();
		end

		// last phase at full rate on both sides
		bursts_on = 1'b0;
		random_config();
		queue_random(150);
		wait_drained();

		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
